// ----- design/assert_macros.svh -----
// assertion helpers for the decoder modules, included by chd_back
// each macro expects aclk and aresetn in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define CHD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// condition must never be true out of reset
`define CHD_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

// ----- design/chd_pkg.sv -----
// ----------------------------------------------------------------------------
// chd_pkg
// types, constants and helpers shared by the chunked body decoder
// ----------------------------------------------------------------------------
package chd_pkg;

    localparam int SIZE_BITS  = 32;
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_SP  = 8'h20;
    localparam logic [7:0] CHAR_TAB = 8'h09;

    typedef enum logic [2:0] {
        PH_SIZE  = 3'd0,
        PH_EXT   = 3'd1,
        PH_CR    = 3'd2,
        PH_DATA  = 3'd3,
        PH_TAIL  = 3'd4,
        PH_FINAL = 3'd5,
        PH_DONE  = 3'd6
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       start_body;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       body_done;
        logic       malformed;
    } out_word_t;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       start_body;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_blank;
        logic       is_cr;
        logic       is_lf;
    } token_t;

    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        begin
            r = 5'b0_0000;
            if (c >= 8'h30 && c <= 8'h39) begin
                r = {1'b1, 4'(c - 8'h30)};
            end else if (c >= 8'h61 && c <= 8'h66) begin
                r = {1'b1, 4'(c - 8'h57)};
            end else if (c >= 8'h41 && c <= 8'h46) begin
                r = {1'b1, 4'(c - 8'h37)};
            end
            return r;
        end
    endfunction

endpackage

// ----- design/chd_front.sv -----
// ----------------------------------------------------------------------------
// chd_front
// accepts input words and classifies each byte into a token for the queue
// ----------------------------------------------------------------------------
module chd_front (
    input  logic              s_valid,
    output logic              s_ready,
    input  chd_pkg::in_word_t s_data,
    input  logic              q_full,
    output logic              q_push,
    output chd_pkg::token_t   q_token
);
    import chd_pkg::*;

    logic [4:0] hex_w;

    assign hex_w   = hex_decode(s_data.in_byte);
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_token.data       = s_data.in_byte;
        q_token.start_body = s_data.start_body;
        q_token.is_hex     = hex_w[4];
        q_token.hex_val    = hex_w[3:0];
        q_token.is_blank   = (s_data.in_byte == CHAR_SP) || (s_data.in_byte == CHAR_TAB);
        q_token.is_cr      = (s_data.in_byte == CHAR_CR);
        q_token.is_lf      = (s_data.in_byte == CHAR_LF);
    end

endmodule

// ----- design/chd_fifo.sv -----
// ----------------------------------------------------------------------------
// chd_fifo
// short token queue between front and back
// ----------------------------------------------------------------------------
module chd_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  chd_pkg::token_t push_token,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output chd_pkg::token_t pop_token
);
    import chd_pkg::*;

    token_t           mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_token = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_token;
        end
    end

endmodule

// ----- design/chd_back.sv -----
// ----------------------------------------------------------------------------
// chd_back
// chunk parser state machine with registered result word
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chd_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_not_empty,
    input  chd_pkg::token_t    q_token,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output chd_pkg::out_word_t m_data
);
    import chd_pkg::*;

    phase_t               phase_reg, phase_next;
    logic [SIZE_BITS-1:0] remain_reg, remain_next;
    logic [1:0]           skip_reg, skip_next;
    logic                 digit_reg, digit_next;
    logic                 err_reg, err_next;
    logic                 m_valid_reg, m_valid_next;
    out_word_t            m_data_reg, m_data_next;

    phase_t               phase_cur;
    logic [SIZE_BITS-1:0] remain_cur;
    logic [1:0]           skip_cur, skip_inc;
    logic                 digit_cur, err_cur, done_w;

    assign q_pop   = q_not_empty && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        // start of a new body wipes the parser first
        phase_cur  = q_token.start_body ? PH_SIZE : phase_reg;
        remain_cur = q_token.start_body ? '0 : remain_reg;
        skip_cur   = q_token.start_body ? 2'd0 : skip_reg;
        digit_cur  = q_token.start_body ? 1'b0 : digit_reg;
        err_cur    = q_token.start_body ? 1'b0 : err_reg;
        skip_inc   = skip_cur + 2'd1;

        phase_next  = phase_cur;
        remain_next = remain_cur;
        skip_next   = skip_cur;
        digit_next  = digit_cur;
        err_next    = err_cur;
        m_data_next = m_data_reg;
        m_data_next.out_byte  = 8'h00;
        m_data_next.out_valid = 1'b0;

        case (phase_cur)
            PH_SIZE: begin
                if (q_token.is_hex) begin
                    if (remain_cur[SIZE_BITS-1 -: 4] != 4'h0) begin
                        err_next   = 1'b1;
                        phase_next = PH_DONE;
                    end else begin
                        remain_next = {remain_cur[SIZE_BITS-5:0], q_token.hex_val};
                        digit_next  = 1'b1;
                    end
                end else if (!digit_cur && q_token.is_blank) begin
                    phase_next = PH_SIZE;
                end else if (!digit_cur) begin
                    err_next   = 1'b1;
                    phase_next = PH_DONE;
                end else begin
                    phase_next = q_token.is_cr ? PH_CR : PH_EXT;
                end
            end
            PH_EXT: begin
                if (q_token.is_cr) begin
                    phase_next = PH_CR;
                end
            end
            PH_CR: begin
                if (q_token.is_lf) begin
                    skip_next  = 2'd0;
                    phase_next = (remain_cur == '0) ? PH_FINAL : PH_DATA;
                end else if (!q_token.is_cr) begin
                    phase_next = PH_EXT;
                end
            end
            PH_DATA: begin
                m_data_next.out_byte  = q_token.data;
                m_data_next.out_valid = 1'b1;
                remain_next           = remain_cur - 1'b1;
                if (remain_cur == SIZE_BITS'(1)) begin
                    skip_next  = 2'd0;
                    phase_next = PH_TAIL;
                end
            end
            PH_TAIL: begin
                skip_next = skip_inc;
                if (skip_inc >= 2'd2) begin
                    // next size line
                    phase_next  = PH_SIZE;
                    remain_next = '0;
                    skip_next   = 2'd0;
                    digit_next  = 1'b0;
                end
            end
            PH_FINAL: begin
                skip_next = skip_inc;
                if (skip_inc >= 2'd2) begin
                    phase_next = PH_DONE;
                end
            end
            default: begin
                phase_next = PH_DONE;
            end
        endcase

        done_w                = (phase_next == PH_DONE);
        m_data_next.body_done = done_w;
        m_data_next.malformed = done_w && err_next;

        m_valid_next = m_valid_reg;
        if (q_pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SIZE;
            remain_reg  <= '0;
            skip_reg    <= 2'd0;
            digit_reg   <= 1'b0;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (q_pop) begin
                phase_reg  <= phase_next;
                remain_reg <= remain_next;
                skip_reg   <= skip_next;
                digit_reg  <= digit_next;
                err_reg    <= err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_data_reg <= m_data_next;
        end
    end

    `CHD_NEVER(a_data_count_zero, (phase_reg == PH_DATA) && (remain_reg == '0), "payload phase with nothing left")
    `CHD_ASSERT(a_malformed_done, (m_valid_reg && m_data_reg.malformed) |-> m_data_reg.body_done, "malformed without body_done")
    `CHD_NEVER(a_payload_after_done, m_valid_reg && m_data_reg.out_valid && m_data_reg.body_done, "payload word flagged done")
    `CHD_ASSERT(a_stall_holds, (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_data_reg) && $stable(phase_reg)), "stalled result or state changed")

endmodule

// ----- design/http_chunked_body_decoder_top.sv -----
// an accepted word is written into the token queue, then parsed into the registered result word on m_
// throughput: one word per cycle while m_ready does not stall the result register in chd_back
// a two-entry token queue lets input and output stall independently
// reset: aresetn, synchronous, active low; parser returns to the size line start
// and both queue and output register come up empty
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_top
// decodes an http/1.1 chunked body, one raw byte per word, into payload bytes
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  chd_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output chd_pkg::out_word_t m_data
);
    import chd_pkg::*;

    // front to queue
    logic   q_push;
    logic   q_full;
    token_t push_token;

    // queue to back
    logic   q_pop;
    logic   q_not_empty;
    token_t pop_token;

    // front: classify each byte (hex digit, blank, cr, lf) as it is taken
    chd_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_token (push_token)
    );

    // short queue decouples word intake from result delivery
    chd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_token (push_token),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .pop_token  (pop_token)
    );

    // back: size line parsing, payload pass-through, tail skipping, done flags
    chd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_token     (pop_token),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule
